FILE: hdl/vau_pkg.sv
// Package with the constants, action codes and transaction types of the vector arithmetic unit.
`default_nettype none
package vau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ROOT_BITS = 32;
	localparam int DIV_STEPS = FRAC_BITS + 1;

	typedef enum logic [2:0] {
		ACT_ADD       = 3'd0,
		ACT_SUB       = 3'd1,
		ACT_DOT       = 3'd2,
		ACT_CROSS     = 3'd3,
		ACT_NORM      = 3'd4,
		ACT_NORMALIZE = 3'd5,
		ACT_EQUAL     = 3'd6
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
	} op_t;

	typedef struct packed {
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic signed [31:0] res_z;
		logic signed [63:0] res_scalar;
		logic               equal;
	} res_t;

endpackage
`default_nettype wire

FILE: hdl/vector3_arith_unit.sv
// Top level of the pipelined three-component fixed-point vector arithmetic unit.
//
// Operand transactions arrive on op_valid / op_stall / op and results leave on
// res_valid / res_stall / res. A transaction moves when valid is high and stall low.
// Every action takes the same path, so results leave in arrival order.
// The stages are: operand multiply, sum and shift, one square-root bit per stage
// over ROOT_BITS stages, one quotient bit per stage over DIV_STEPS stages for the
// three normalize lanes, and the output register.
// A transaction may enter whenever op_stall is low, so one per cycle unless stalled.
// When the receiver stalls while a result is held, the whole pipeline freezes and
// op_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline starts empty.
`default_nettype none
module vector3_arith_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     op_valid,
	output logic          op_stall,
	input  vau_pkg::op_t  op,
	output logic          res_valid,
	input  wire logic     res_stall,
	output vau_pkg::res_t res
);

	localparam int F  = vau_pkg::FRAC_BITS;
	localparam int RB = vau_pkg::ROOT_BITS;
	localparam int DS = vau_pkg::DIV_STEPS;

	typedef struct packed {
		vau_pkg::action_t  action;
		logic [2:0][31:0]  a;
		logic [2:0][31:0]  vec;
		logic [63:0]       scalar;
		logic              equal;
	} carry_t;

	typedef struct packed {
		carry_t           c;
		logic [5:0][63:0] prod;
	} mul_t;

	typedef struct packed {
		carry_t      c;
		logic [63:0] sumsq;
	} sum_t;

	typedef struct packed {
		carry_t        c;
		logic [63:0]   d;
		logic [RB-1:0] root;
	} sqrt_t;

	typedef struct packed {
		carry_t             c;
		logic [RB-1:0]      n;
		logic [2:0][RB-1:0] rem;
		logic [2:0][DS-1:0] q;
	} div_t;

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		logic [31:0] r;
		if (v > 65'sh0_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic adv;
	assign adv      = !(res_valid && res_stall);
	assign op_stall = !adv;

	logic [2:0][31:0]   av;
	logic [2:0][31:0]   bv;
	logic signed [31:0] ma [3];
	logic signed [31:0] mb [3];
	mul_t               mul_nx;
	mul_t               mul_s1;
	logic               v_s1;

	assign av = {op.a_z, op.a_y, op.a_x};
	assign bv = {op.b_z, op.b_y, op.b_x};

	always_comb begin
		logic signed [63:0] p;
		logic signed [32:0] s;
		s = '0;
		for (int j = 0; j < 3; j++) begin
			ma[j] = $signed(av[j]);
			mb[j] = $signed(bv[j]);
		end
		case (op.action)
			vau_pkg::ACT_DOT: begin
			end
			vau_pkg::ACT_NORM, vau_pkg::ACT_NORMALIZE: begin
				for (int j = 0; j < 3; j++) mb[j] = $signed(av[j]);
			end
			default: begin
				ma[0] = $signed(av[1]); mb[0] = $signed(bv[2]);
				ma[1] = $signed(av[2]); mb[1] = $signed(bv[1]);
				ma[2] = $signed(av[2]); mb[2] = $signed(bv[0]);
			end
		endcase
		mul_nx.c.action = op.action;
		mul_nx.c.a      = av;
		mul_nx.c.scalar = '0;
		mul_nx.c.equal  = (op.action == vau_pkg::ACT_EQUAL) && (av == bv);
		for (int j = 0; j < 3; j++) begin
			p = ma[j] * mb[j];
			mul_nx.prod[j] = p;
		end
		p = $signed(av[0]) * $signed(bv[2]);
		mul_nx.prod[3] = p;
		p = $signed(av[0]) * $signed(bv[1]);
		mul_nx.prod[4] = p;
		p = $signed(av[1]) * $signed(bv[0]);
		mul_nx.prod[5] = p;
		for (int j = 0; j < 3; j++) begin
			case (op.action)
				vau_pkg::ACT_ADD: begin
					s = $signed({av[j][31], av[j]}) + $signed({bv[j][31], bv[j]});
					mul_nx.c.vec[j] = sat32(65'(s));
				end
				vau_pkg::ACT_SUB: begin
					s = $signed({av[j][31], av[j]}) - $signed({bv[j][31], bv[j]});
					mul_nx.c.vec[j] = sat32(65'(s));
				end
				default: begin
					mul_nx.c.vec[j] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1 <= mul_nx;
		end
	end

	sum_t sum_nx;
	sum_t sum_s2;
	logic v_s2;

	always_comb begin
		logic signed [65:0] dsum;
		logic signed [64:0] dif [3];
		logic signed [64:0] sh;
		sh           = '0;
		sum_nx.c     = mul_s1.c;
		sum_nx.sumsq = mul_s1.prod[0] + mul_s1.prod[1] + mul_s1.prod[2];
		dsum = 66'($signed(mul_s1.prod[0])) + 66'($signed(mul_s1.prod[1]))
			+ 66'($signed(mul_s1.prod[2]));
		dif[0] = 65'($signed(mul_s1.prod[0])) - 65'($signed(mul_s1.prod[1]));
		dif[1] = 65'($signed(mul_s1.prod[2])) - 65'($signed(mul_s1.prod[3]));
		dif[2] = 65'($signed(mul_s1.prod[4])) - 65'($signed(mul_s1.prod[5]));
		if (mul_s1.c.action == vau_pkg::ACT_DOT) begin
			sum_nx.c.scalar = 64'(dsum >>> F);
		end
		if (mul_s1.c.action == vau_pkg::ACT_CROSS) begin
			for (int j = 0; j < 3; j++) begin
				sh = dif[j] >>> F;
				sum_nx.c.vec[j] = sat32(sh);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_nx;
		end
	end

	sqrt_t sqrt_in  [RB];
	sqrt_t sqrt_nx  [RB];
	sqrt_t sqrt_s   [RB];
	logic  sqrt_vin [RB];
	logic  sqrt_v   [RB];

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		localparam int BIT = RB - 1 - k;

		if (k == 0) begin : g_first
			always_comb begin
				sqrt_in[k].c    = sum_s2.c;
				sqrt_in[k].d    = sum_s2.sumsq;
				sqrt_in[k].root = '0;
				sqrt_vin[k]     = v_s2;
			end
		end else begin : g_next
			always_comb begin
				sqrt_in[k]  = sqrt_s[k-1];
				sqrt_vin[k] = sqrt_v[k-1];
			end
		end

		always_comb begin
			logic [65:0] trial;
			trial = (66'(sqrt_in[k].root) << (BIT + 1)) | (66'(1) << (2 * BIT));
			sqrt_nx[k] = sqrt_in[k];
			if ({2'b00, sqrt_in[k].d} >= trial) begin
				sqrt_nx[k].d    = sqrt_in[k].d - trial[63:0];
				sqrt_nx[k].root = sqrt_in[k].root | (RB'(1) << BIT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_v[k] <= 1'b0;
			end else if (adv) begin
				sqrt_v[k] <= sqrt_vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_s[k] <= sqrt_nx[k];
			end
		end
	end

	div_t       div_in  [DS];
	div_t       div_nx  [DS];
	div_t       div_s   [DS];
	logic [2:0] div_bit [DS];
	logic       div_vin [DS];
	logic       div_v   [DS];

	for (genvar k = 0; k < DS; k++) begin : g_div
		if (k == 0) begin : g_first
			always_comb begin
				logic [31:0] mag;
				div_in[k].c = sqrt_s[RB-1].c;
				if (sqrt_s[RB-1].c.action == vau_pkg::ACT_NORM) begin
					div_in[k].c.scalar = 64'(sqrt_s[RB-1].root);
				end
				div_in[k].n = sqrt_s[RB-1].root;
				div_in[k].q = '0;
				for (int j = 0; j < 3; j++) begin
					mag = sqrt_s[RB-1].c.a[j][31] ? -sqrt_s[RB-1].c.a[j]
						: sqrt_s[RB-1].c.a[j];
					div_in[k].rem[j] = RB'(mag >> 1);
					div_bit[k][j]    = mag[0];
				end
				div_vin[k] = sqrt_v[RB-1];
			end
		end else begin : g_next
			always_comb begin
				div_in[k]  = div_s[k-1];
				div_bit[k] = '0;
				div_vin[k] = div_v[k-1];
			end
		end

		always_comb begin
			logic [RB:0] t;
			logic        ge;
			div_nx[k] = div_in[k];
			for (int j = 0; j < 3; j++) begin
				t  = {div_in[k].rem[j], div_bit[k][j]};
				ge = t >= {1'b0, div_in[k].n};
				div_nx[k].rem[j] = ge ? RB'(t - {1'b0, div_in[k].n}) : RB'(t);
				div_nx[k].q[j]   = (div_in[k].q[j] << 1) | DS'(ge);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k] <= 1'b0;
			end else if (adv) begin
				div_v[k] <= div_vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_nx[k];
			end
		end
	end

	vau_pkg::res_t res_nx;

	always_comb begin
		logic [2:0][31:0] v;
		logic [31:0]      qv;
		qv = '0;
		v = div_s[DS-1].c.vec;
		if (div_s[DS-1].c.action == vau_pkg::ACT_NORMALIZE) begin
			for (int j = 0; j < 3; j++) begin
				qv = 32'(div_s[DS-1].q[j]);
				if (div_s[DS-1].n == '0) begin
					v[j] = div_s[DS-1].c.a[j];
				end else begin
					v[j] = div_s[DS-1].c.a[j][31] ? -qv : qv;
				end
			end
		end
		res_nx.res_x      = v[0];
		res_nx.res_y      = v[1];
		res_nx.res_z      = v[2];
		res_nx.res_scalar = div_s[DS-1].c.scalar;
		res_nx.equal      = div_s[DS-1].c.equal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= div_v[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= res_nx;
		end
	end

	a_root_tight : assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_v[RB-1] |-> {1'b0, sqrt_s[RB-1].d} <= 65'({sqrt_s[RB-1].root, 1'b0}))
		else $error("square root remainder exceeds twice the root");

	a_div_rem : assert property (@(posedge clk) disable iff (!arst_n)
		div_v[DS-1] && div_s[DS-1].c.action == vau_pkg::ACT_NORMALIZE
		&& div_s[DS-1].n != '0
		|-> div_s[DS-1].rem[0] < div_s[DS-1].n && div_s[DS-1].rem[1] < div_s[DS-1].n
		&& div_s[DS-1].rem[2] < div_s[DS-1].n)
		else $error("normalize remainder not below the norm");

	a_equal_only : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.equal |-> res.res_x == '0 && res.res_y == '0
		&& res.res_z == '0 && res.res_scalar == '0)
		else $error("equality result carries non-zero data");

endmodule
`default_nettype wire

FILE: tb/vector3_arith_unit_test.sv
// Testbench for the vector arithmetic unit, checking every result against a fixed-point predictor.
`timescale 1ns / 100ps
module vector3_arith_unit_test;

	class vau_scoreboard;
		vau_pkg::res_t pending[$];
		int errors = 0;

		function logic signed [31:0] clamp32(logic signed [67:0] v);
			if (v > 68'sd2147483647) return 32'sh7fffffff;
			if (v < -68'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function logic [63:0] magnitude(logic signed [31:0] v);
			longint w;
			w = v;
			return (w < 0) ? -w : w;
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] s);
			logic [63:0] root, cand;
			root = 0;
			for (int i = 31; i >= 0; i--) begin
				cand = root | (64'd1 << i);
				if (cand * cand <= s) root = cand;
			end
			return root;
		endfunction

		function logic signed [67:0] prod(logic signed [31:0] x, logic signed [31:0] y);
			longint p;
			logic signed [67:0] w;
			p = longint'(x) * longint'(y);
			w = p;
			return w;
		endfunction

		function vau_pkg::res_t predict(vau_pkg::op_t o);
			vau_pkg::res_t r;
			logic signed [31:0] a [3];
			logic signed [31:0] b [3];
			logic signed [67:0] acc;
			logic [63:0] sq, n, q;
			r = '0;
			a[0] = o.a_x; a[1] = o.a_y; a[2] = o.a_z;
			b[0] = o.b_x; b[1] = o.b_y; b[2] = o.b_z;
			case (o.action)
				vau_pkg::ACT_ADD: begin
					r.res_x = clamp32(68'(a[0]) + 68'(b[0]));
					r.res_y = clamp32(68'(a[1]) + 68'(b[1]));
					r.res_z = clamp32(68'(a[2]) + 68'(b[2]));
				end
				vau_pkg::ACT_SUB: begin
					r.res_x = clamp32(68'(a[0]) - 68'(b[0]));
					r.res_y = clamp32(68'(a[1]) - 68'(b[1]));
					r.res_z = clamp32(68'(a[2]) - 68'(b[2]));
				end
				vau_pkg::ACT_DOT: begin
					acc = prod(a[0], b[0]) + prod(a[1], b[1]) + prod(a[2], b[2]);
					acc = acc >>> vau_pkg::FRAC_BITS;
					r.res_scalar = acc[63:0];
				end
				vau_pkg::ACT_CROSS: begin
					r.res_x = clamp32((prod(a[1], b[2]) - prod(a[2], b[1]))
						>>> vau_pkg::FRAC_BITS);
					r.res_y = clamp32((prod(a[2], b[0]) - prod(a[0], b[2]))
						>>> vau_pkg::FRAC_BITS);
					r.res_z = clamp32((prod(a[0], b[1]) - prod(a[1], b[0]))
						>>> vau_pkg::FRAC_BITS);
				end
				vau_pkg::ACT_NORM, vau_pkg::ACT_NORMALIZE: begin
					sq = 0;
					for (int i = 0; i < 3; i++) sq += magnitude(a[i]) * magnitude(a[i]);
					n = int_sqrt(sq);
					if (o.action == vau_pkg::ACT_NORM) begin
						r.res_scalar = n;
					end else begin
						for (int i = 0; i < 3; i++) begin
							if (n == 0) begin
								acc = a[i];
							end else begin
								q = (magnitude(a[i]) << vau_pkg::FRAC_BITS) / n;
								acc = {4'b0, q};
								if (a[i] < 0) acc = -acc;
							end
							if (i == 0) r.res_x = clamp32(acc);
							else if (i == 1) r.res_y = clamp32(acc);
							else r.res_z = clamp32(acc);
						end
					end
				end
				vau_pkg::ACT_EQUAL:
					r.equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_op(vau_pkg::op_t o);
			pending.push_back(predict(o));
		endfunction

		function void check_res(vau_pkg::res_t got);
			vau_pkg::res_t want;
			if (pending.size() == 0) begin
				$error("result transaction with no expectation waiting");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.res_x !== want.res_x) begin
				$error("res_x expected %0d actual %0d", want.res_x, got.res_x);
				errors++;
			end
			if (got.res_y !== want.res_y) begin
				$error("res_y expected %0d actual %0d", want.res_y, got.res_y);
				errors++;
			end
			if (got.res_z !== want.res_z) begin
				$error("res_z expected %0d actual %0d", want.res_z, got.res_z);
				errors++;
			end
			if (got.res_scalar !== want.res_scalar) begin
				$error("res_scalar expected %0d actual %0d", want.res_scalar, got.res_scalar);
				errors++;
			end
			if (got.equal !== want.equal) begin
				$error("equal expected %0d actual %0d", want.equal, got.equal);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic op_valid;
	logic op_stall;
	vau_pkg::op_t op;
	logic res_valid;
	logic res_stall;
	vau_pkg::res_t res;
	vau_scoreboard sb;
	vau_pkg::op_t directed[$];
	bit sending_done = 0;
	int cycle_count = 0;

	vector3_arith_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall), .op(op),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function logic signed [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3, 4: return $urandom();
			default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	function vau_pkg::op_t make_op(int act, logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] az, logic signed [31:0] bx, logic signed [31:0] by,
			logic signed [31:0] bz);
		vau_pkg::op_t o;
		o.action = vau_pkg::action_t'(act[2:0]);
		o.a_x = ax; o.a_y = ay; o.a_z = az;
		o.b_x = bx; o.b_y = by; o.b_z = bz;
		return o;
	endfunction

	function vau_pkg::op_t random_op();
		vau_pkg::op_t o;
		o = make_op($urandom_range(0, 7), rand_comp(), rand_comp(), rand_comp(),
			rand_comp(), rand_comp(), rand_comp());
		if (o.action == vau_pkg::ACT_EQUAL && $urandom_range(0, 1)) begin
			o.b_x = o.a_x; o.b_y = o.a_y; o.b_z = o.a_z;
			if ($urandom_range(0, 2) == 0) o.b_z[$urandom_range(0, 31)] ^= 1'b1;
		end
		return o;
	endfunction

	task automatic send_op(vau_pkg::op_t o, bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 19) begin
			op_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		op_valid <= 1'b1;
		op <= o;
		do @(posedge clk); while (op_stall);
		sb.note_op(o);
	endtask

	initial begin
		localparam logic signed [31:0] MX = 32'sh7fffffff;
		localparam logic signed [31:0] MN = 32'sh80000000;
		localparam logic signed [31:0] ONE = 32'sh00010000;
		sb = new();
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed.push_back(make_op(vau_pkg::ACT_ADD, MX, MN, ONE, ONE, MN, -ONE));
		directed.push_back(make_op(vau_pkg::ACT_ADD, -1, 0, MX, 1, 0, MN));
		directed.push_back(make_op(vau_pkg::ACT_SUB, MN, MX, 0, ONE, MN, 0));
		directed.push_back(make_op(vau_pkg::ACT_SUB, 0, -1, MX, MN, 1, MX));
		directed.push_back(make_op(vau_pkg::ACT_DOT, MX, MX, MX, MX, MX, MX));
		directed.push_back(make_op(vau_pkg::ACT_DOT, MN, MN, MN, MN, MN, MN));
		directed.push_back(make_op(vau_pkg::ACT_DOT, MN, MX, -1, MX, MN, 1));
		directed.push_back(make_op(vau_pkg::ACT_CROSS, ONE, 0, 0, 0, ONE, 0));
		directed.push_back(make_op(vau_pkg::ACT_CROSS, 0, 0, 0, MX, MN, ONE));
		directed.push_back(make_op(vau_pkg::ACT_CROSS, MX, MN, MX, MN, MX, MN));
		directed.push_back(make_op(vau_pkg::ACT_CROSS, -1, 1, -3, 5, -7, 2));
		directed.push_back(make_op(vau_pkg::ACT_NORM, MN, MN, MN, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_NORM, 0, 0, 0, MX, MX, MX));
		directed.push_back(make_op(vau_pkg::ACT_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_NORMALIZE, 0, 0, 0, ONE, ONE, ONE));
		directed.push_back(make_op(vau_pkg::ACT_NORMALIZE, 3 * ONE, -4 * ONE, 0, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_NORMALIZE, MN, 0, 0, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_NORMALIZE, 1, 0, 0, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_NORMALIZE, MX, MN, 1, 0, 0, 0));
		directed.push_back(make_op(vau_pkg::ACT_EQUAL, MX, MN, 0, MX, MN, 0));
		directed.push_back(make_op(vau_pkg::ACT_EQUAL, MX, MN, 0, MX, MN, 1));
		directed.push_back(make_op(vau_pkg::ACT_EQUAL, -1, -1, -1, -1, -1, -1));
		directed.push_back(make_op(7, MX, MX, MX, MN, MN, MN));
		foreach (directed[i]) send_op(directed[i], 1'b1);
		for (int i = 0; i < 1030; i++) send_op(random_op(), !(i >= 400 && i < 600));
		op_valid <= 1'b0;
		sending_done = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		int hold;
		res_stall <= 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (cycle_count == 1500) hold = 300;
			if (hold > 0) begin
				hold--;
				res_stall <= 1'b1;
			end else if (cycle_count > 300 && cycle_count < 700) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(0, 99) < 19);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_res(res);
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
